### hw/rtl/assert_macros.svh
// Assertion macros used by the checker file f12bd_checker.sv.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every clock edge outside reset.
`define F12BD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Check prop at every clock edge, reset included.
`define F12BD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) \
      else $error(msg);

`endif

### hw/rtl/f12bd_pkg.sv
// Types, constants and the round function of the 12-bit Feistel decrypt block.
// No dependencies.
package f12bd_pkg;

   localparam int HALF_WIDTH      = 6;
   localparam int BLOCK_WIDTH     = 2 * HALF_WIDTH;
   localparam int KEY_WIDTH       = 8;
   localparam int ETAB_WIDTH      = 24;
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = 24;

   typedef logic [HALF_WIDTH-1:0]      half_type;
   typedef logic [BLOCK_WIDTH-1:0]     block_type;
   typedef logic [KEY_WIDTH-1:0]       key_type;
   typedef logic [ETAB_WIDTH-1:0]      etab_type;
   typedef logic [CSR_INDEX_WIDTH-1:0] csr_index_type;
   typedef logic [CSR_DATA_WIDTH-1:0]  csr_data_type;

   localparam csr_index_type CSR_CIPHER_KEY      = 1'd0;
   localparam csr_index_type CSR_EXPANSION_TABLE = 1'd1;

   localparam key_type  KEY_RESET  = 8'd0;
   localparam etab_type ETAB_RESET = 24'd370341;

   localparam logic [2:0] SEL_LAST = 3'd5;

   localparam logic [2:0] SBOX_A [16] = '{3'd5, 3'd2, 3'd1, 3'd6, 3'd3, 3'd4, 3'd7, 3'd0,
                                         3'd1, 3'd4, 3'd6, 3'd2, 3'd0, 3'd7, 3'd5, 3'd3};
   localparam logic [2:0] SBOX_B [16] = '{3'd4, 3'd0, 3'd6, 3'd5, 3'd7, 3'd1, 3'd3, 3'd2,
                                         3'd5, 3'd3, 3'd0, 3'd7, 3'd6, 3'd2, 3'd1, 3'd4};

   typedef struct packed {
      logic     valid;
      half_type left;
      half_type right;
   } stage_type;

   typedef struct packed {
      key_type  key;
      etab_type etab;
   } cfg_type;

   // Expand R to 8 bits, mix in the round key, run both S-boxes.
   function automatic half_type round_f(half_type r, key_type rkey, etab_type etab);
      key_type    e;
      key_type    x;
      logic [2:0] sel;
      e = '0;
      for (int i = 0; i < KEY_WIDTH; i++) begin
         sel = etab[ETAB_WIDTH-1-3*i -: 3];
         if (sel > SEL_LAST) begin
            sel = SEL_LAST;
         end
         e[KEY_WIDTH-1-i] = r[HALF_WIDTH-1-sel];
      end
      x = e ^ rkey;
      return {SBOX_A[x[7:4]], SBOX_B[x[3:0]]};
   endfunction

endpackage

### hw/rtl/f12bd_if.sv
// Channel interfaces: block request, block response and register write.
// Depends on f12bd_pkg.
interface f12bd_req_if;
   import f12bd_pkg::*;
   logic      valid;
   logic      ready;
   block_type block_in;
   modport source (output valid, output block_in, input ready);
   modport sink   (input valid, input block_in, output ready);
endinterface

interface f12bd_rsp_if;
   import f12bd_pkg::*;
   logic      valid;
   logic      ready;
   block_type block_out;
   modport source (output valid, output block_out, input ready);
   modport sink   (input valid, input block_out, output ready);
endinterface

interface f12bd_csr_if;
   import f12bd_pkg::*;
   logic          valid;
   logic          ready;
   csr_index_type index;
   csr_data_type  data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

### hw/rtl/f12bd_round.sv
// One registered Feistel round of the decrypt pipeline.
// Depends on f12bd_pkg.
module f12bd_round #(
   parameter int ROT_AMOUNT = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  f12bd_pkg::cfg_type   cfg,
   input  f12bd_pkg::stage_type stage_in,
   output f12bd_pkg::stage_type stage_out
);
   import f12bd_pkg::*;

   logic [2*KEY_WIDTH-1:0] key_pair;
   key_type                rkey;
   half_type               f_val;
   logic                   valid_ff;
   half_type               left_ff;
   half_type               right_ff;
   half_type               left_in;
   half_type               right_in;

   // Rotate left by a fixed amount: take a window of the doubled key.
   assign key_pair = {cfg.key, cfg.key};
   assign rkey     = key_pair[2*KEY_WIDTH-1-ROT_AMOUNT -: KEY_WIDTH];

   assign f_val    = round_f(stage_in.right, rkey, cfg.etab);
   assign left_in  = stage_in.right;
   assign right_in = stage_in.left ^ f_val;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= stage_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         left_ff  <= left_in;
         right_ff <= right_in;
      end
   end

   assign stage_out = '{valid: valid_ff, left: left_ff, right: right_ff};

endmodule

### hw/rtl/feistel12_block_decrypt_top.sv
// Top level of the 12-bit Feistel block decrypt pipeline.
// Depends on f12bd_pkg, f12bd_if and f12bd_round.
//
//   channel   direction  word                         notes
//   req_bus   in         block_in, 12 bits            bit 11 first, left half 11..6
//   rsp_bus   out        block_out, 12 bits           final right half in 11..6
//   csr_bus   in         index 1 bit, data 24 bits    0: cipher_key, 1: expansion_table
//
// One round per register stage, behind an input register: while rsp_bus does not stall,
// a block enters every cycle and passes the input and ROUNDS round registers in turn to
// rsp_bus; throughput is then one block per cycle, as all stages share one advance.
// A stall at rsp_bus freezes the whole pipe; req_ready drops only while the last
// stage holds a word that is not taken. Reset clears valid bits and restores
// both registers; register writes are always taken.
module feistel12_block_decrypt_top #(
   parameter int ROUNDS = 7
) (
   input  logic       clock,
   input  logic       reset,
   f12bd_req_if.sink   req_bus,
   f12bd_rsp_if.source rsp_bus,
   f12bd_csr_if.sink   csr_bus
);
   import f12bd_pkg::*;

   key_type   key_ff;
   etab_type  etab_ff;
   cfg_type   cfg;
   logic      advance;
   logic      in_valid_ff;
   half_type  in_left_ff;
   half_type  in_right_ff;
   stage_type pipe [ROUNDS+1];

   // Register file
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff  <= KEY_RESET;
         etab_ff <= ETAB_RESET;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_CIPHER_KEY: begin
               key_ff <= csr_bus.data[KEY_WIDTH-1:0];
            end
            CSR_EXPANSION_TABLE: begin
               etab_ff <= csr_bus.data[ETAB_WIDTH-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign cfg = '{key: key_ff, etab: etab_ff};

   // Hold everything while the output word waits.
   assign advance       = !pipe[ROUNDS].valid || rsp_bus.ready;
   assign req_bus.ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (advance) begin
         in_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         in_left_ff  <= req_bus.block_in[BLOCK_WIDTH-1 -: HALF_WIDTH];
         in_right_ff <= req_bus.block_in[HALF_WIDTH-1:0];
      end
   end

   assign pipe[0] = '{valid: in_valid_ff, left: in_left_ff, right: in_right_ff};

   for (genvar gi = 0; gi < ROUNDS; gi++) begin : g_round
      // Round gi+1 starts its key at position (ROUNDS - round + 1) mod 8.
      f12bd_round #(
         .ROT_AMOUNT ((ROUNDS - gi) % KEY_WIDTH)
      ) u_round (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .cfg       (cfg),
         .stage_in  (pipe[gi]),
         .stage_out (pipe[gi+1])
      );
   end

   assign rsp_bus.valid     = pipe[ROUNDS].valid;
   assign rsp_bus.block_out = {pipe[ROUNDS].right, pipe[ROUNDS].left};

endmodule

### hw/rtl/f12bd_checker.sv
// Port-level checks of the Feistel decrypt top level, bound to every instance.
// Depends on f12bd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module f12bd_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input f12bd_pkg::block_type rsp_block,
   input logic                 csr_valid,
   input logic                 csr_ready
);
   import f12bd_pkg::*;

   `F12BD_ASSERT_ALWAYS(a_reset_empties, clock, reset |=> !rsp_valid, "output valid after reset")
   `F12BD_ASSERT(a_ready_when_empty, clock, reset, !rsp_valid |-> req_ready, "blocked while empty")
   `F12BD_ASSERT(a_ready_when_taken, clock, reset, rsp_ready |-> req_ready, "blocked while draining")
   `F12BD_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_block), "stalled word changed")
   `F12BD_ASSERT(a_csr_taken, clock, reset, csr_valid |-> csr_ready, "register write refused")

endmodule

bind feistel12_block_decrypt_top f12bd_checker u_f12bd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .rsp_block (rsp_bus.block_out),
   .csr_valid (csr_bus.valid),
   .csr_ready (csr_bus.ready)
);
